// ----- design/wpd_pkg.sv -----
package wpd_pkg;

  // span arithmetic width: 32-bit signed frames plus headroom for differences
  localparam int SPAN_W      = 34;
  localparam int DVD_W       = 32;
  localparam int DSR_W       = 17;
  localparam int FRAME_MAX_W = 20;
  localparam int COUNT_W     = 21;
  localparam int CFG_W       = 17;
  localparam int QDEPTH      = 2;

  localparam logic [15:0] SILENCE_LEVEL = 16'h8000;
  localparam logic [15:0] SIGN_FLIP     = 16'h8000;
  localparam logic [15:0] LEVEL_TOP     = 16'hFFFF;

  typedef logic signed [SPAN_W-1:0] span_t;

  typedef enum logic {
    REQ_LOAD  = 1'b0,
    REQ_QUERY = 1'b1
  } req_t;

  typedef enum logic [2:0] {
    CFG_FRAME_TOTAL   = 3'd0,
    CFG_LOOP_START    = 3'd1,
    CFG_LOOP_LENGTH   = 3'd2,
    CFG_LOOP_ENABLED  = 3'd3,
    CFG_CHANNEL_COUNT = 3'd4
  } cfg_idx_t;

  typedef struct packed {
    logic               req_type;
    logic [2:0]         load_channel;
    logic [15:0]        load_frame;
    logic signed [15:0] load_sample;
    logic signed [31:0] span_begin;
    logic signed [31:0] span_end;
  } in_item_t;

  typedef struct packed {
    logic [2:0]  channel;
    logic [15:0] min_level;
    logic [15:0] max_level;
    logic        last;
  } out_item_t;

  typedef struct packed {
    logic [16:0] frame_total;
    logic [15:0] loop_start;
    logic [16:0] loop_length;
    logic        loop_enabled;
    logic [3:0]  channel_count;
  } cfg_t;

  // one command handed from the front end to the scan engine
  typedef struct packed {
    logic                   is_load;
    logic                   silent;
    logic [2:0]             load_channel;
    logic [15:0]            load_frame;
    logic [15:0]            load_sample;
    logic [FRAME_MAX_W-1:0] first;
    logic [COUNT_W-1:0]     count;
    logic [3:0]             nch;
  } cmd_t;

  typedef enum logic [2:0] {
    F_IDLE,
    F_PREP,
    F_LOOP,
    F_CLASS,
    F_DIV,
    F_FIN1,
    F_FIN2,
    F_PUSH
  } front_state_t;

  typedef enum logic [1:0] {
    B_IDLE,
    B_SCAN,
    B_DRAIN,
    B_EMIT
  } back_state_t;

endpackage

// ----- design/wpd_stream_if.sv -----
interface wpd_stream_if #(parameter type T = logic);
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// ----- design/waveform_peak_decimator_core.sv -----
// waveform min/max peak decimator
//
// in_ch carries loads (one sample into the per-channel store) and span
// queries; out_ch carries one min/max result per channel in use, channel 0
// first, with last set on the final one. cfg_we/cfg_index/cfg_data write the
// five control registers; write them only while the block is idle.
//
// a front end classifies each transaction and computes the frame span
// (with the remainder divider when a span wraps into the loop), then hands
// a command through a two-entry queue to the scan engine. a load goes
// through the front end's push state and is written to the store as it is
// popped. a query goes through prep, loop, class, the divider when wrapping,
// fin1, fin2 and push; the scan engine pops it, then per channel scans one
// frame per cycle through the single read port of the sample store, drains
// and emits. silent queries skip the scan and only emit, per channel.
//
// reset restores the register defaults and empties the queue; store contents
// stay undefined until loaded. a stalled out_ch holds the result register and
// backs up the scan engine and then the queue; the front end keeps accepting
// until the queue fills.
module waveform_peak_decimator_core import wpd_pkg::*; #(
  parameter int MAX_FRAMES   = 65536,
  parameter int MAX_CHANNELS = 2
) (
  input  logic             clk,
  input  logic             rst_n,
  wpd_stream_if.sink       in_ch,
  wpd_stream_if.source     out_ch,
  input  logic             cfg_we,
  input  logic [2:0]       cfg_index,
  input  logic [CFG_W-1:0] cfg_data
);

  cfg_t       cfg_r, cfg_nxt;

  // command queue between front end and scan engine
  cmd_t       q_mem_r [QDEPTH];
  logic       q_wr_r;
  logic       q_rd_r;
  logic [1:0] q_cnt_r;
  logic       q_full;
  logic       q_empty;
  logic       push;
  logic       pop;
  cmd_t       push_cmd;

  // register writes, unknown indexes dropped
  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      case (cfg_idx_t'(cfg_index))
        CFG_FRAME_TOTAL:   cfg_nxt.frame_total   = cfg_data;
        CFG_LOOP_START:    cfg_nxt.loop_start    = cfg_data[15:0];
        CFG_LOOP_LENGTH:   cfg_nxt.loop_length   = cfg_data;
        CFG_LOOP_ENABLED:  cfg_nxt.loop_enabled  = cfg_data[0];
        CFG_CHANNEL_COUNT: cfg_nxt.channel_count = cfg_data[3:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.frame_total   <= 17'd65536;
      cfg_r.loop_start    <= '0;
      cfg_r.loop_length   <= '0;
      cfg_r.loop_enabled  <= 1'b0;
      cfg_r.channel_count <= 4'd2;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign q_full  = q_cnt_r == 2'(QDEPTH);
  assign q_empty = q_cnt_r == 2'd0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      q_wr_r  <= 1'b0;
      q_rd_r  <= 1'b0;
      q_cnt_r <= '0;
    end else begin
      if (push) q_wr_r <= ~q_wr_r;
      if (pop)  q_rd_r <= ~q_rd_r;
      q_cnt_r <= q_cnt_r + 2'(push) - 2'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push) q_mem_r[q_wr_r] <= push_cmd;
  end

  wpd_front #(
    .MAX_FRAMES   (MAX_FRAMES),
    .MAX_CHANNELS (MAX_CHANNELS)
  ) u_front (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .cfg    (cfg_r),
    .q_full (q_full),
    .push   (push),
    .cmd    (push_cmd)
  );

  wpd_back #(
    .MAX_FRAMES   (MAX_FRAMES),
    .MAX_CHANNELS (MAX_CHANNELS)
  ) u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .q_empty (q_empty),
    .q_head  (q_mem_r[q_rd_r]),
    .pop     (pop),
    .out_ch  (out_ch)
  );

  // queue occupancy stays within its depth
  a_q_bound: assert property (@(posedge clk) disable iff (!rst_n)
    q_cnt_r <= 2'(QDEPTH))
    else $error("command queue over depth");

  // front end never pushes into a full queue
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> !q_full)
    else $error("push into full queue");

  // scan engine never pops an empty queue
  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> !q_empty)
    else $error("pop from empty queue");

  // a query transaction keeps the front end busy for the next cycle
  a_query_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (in_ch.valid && in_ch.ready && in_ch.data.req_type == REQ_QUERY) |=> !in_ch.ready)
    else $error("front end accepted during span setup");

endmodule

// ----- design/wpd_ram.sv -----
module wpd_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ----- design/wpd_divmod.sv -----
module wpd_divmod import wpd_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [DVD_W-1:0] dividend,
  input  logic [DSR_W-1:0] divisor,
  output logic             done,
  output logic [DSR_W-1:0] remainder
);

  localparam int CNT_W = $clog2(DVD_W + 1);

  logic             busy_r;
  logic             done_r;
  logic [CNT_W-1:0] cnt_r;
  logic [DVD_W-1:0] dvd_r;
  logic [DSR_W-1:0] dsr_r;
  logic [DSR_W-1:0] rem_r;
  logic [DSR_W:0]   shifted;
  logic [DSR_W:0]   trial;
  logic             fits;

  // restoring step, one quotient bit per cycle, only the remainder is kept
  always_comb begin
    shifted = {rem_r, dvd_r[DVD_W-1]};
    trial   = shifted - {1'b0, dsr_r};
    fits    = shifted >= {1'b0, dsr_r};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= CNT_W'(DVD_W);
      end else if (busy_r) begin
        cnt_r <= cnt_r - CNT_W'(1);
        if (cnt_r == CNT_W'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      dvd_r <= dividend;
      dsr_r <= divisor;
      rem_r <= '0;
    end else if (busy_r) begin
      rem_r <= fits ? trial[DSR_W-1:0] : shifted[DSR_W-1:0];
      dvd_r <= dvd_r << 1;
    end
  end

  assign done      = done_r;
  assign remainder = rem_r;

endmodule

// ----- design/wpd_front.sv -----
module wpd_front import wpd_pkg::*; #(
  parameter int MAX_FRAMES   = 65536,
  parameter int MAX_CHANNELS = 2
) (
  input  logic       clk,
  input  logic       rst_n,
  wpd_stream_if.sink in_ch,
  input  cfg_t       cfg,
  input  logic       q_full,
  output logic       push,
  output cmd_t       cmd
);

  localparam span_t MAX_FRAMES_S = span_t'(MAX_FRAMES);

  front_state_t     state_r, state_nxt;
  in_item_t         item_r;
  span_t            total_r;
  logic [3:0]       nch_r;
  span_t            ls_r;
  logic [DSR_W-1:0] len_r;
  span_t            width_r;
  span_t            s_r;
  span_t            e_r;
  logic             wrap_r;
  cmd_t             cmd_r;

  logic             load_ok;
  span_t            start_s;
  span_t            end_s;
  span_t            tot_minus_ls;
  span_t            len_calc;
  span_t            ll_s;
  logic             loop_usable;
  logic             start_ge_total;
  logic             silent_case;
  logic             div_start;
  logic             div_done;
  logic [DSR_W-1:0] div_rem;
  logic [DVD_W-1:0] dividend;
  span_t            diff;
  span_t            cnt_calc;

  always_comb begin
    load_ok = (32'(in_ch.data.load_channel) < 32'(MAX_CHANNELS)) &&
              (32'(in_ch.data.load_frame) < 32'(MAX_FRAMES));
    start_s        = span_t'(item_r.span_begin);
    end_s          = span_t'(item_r.span_end);
    ll_s           = span_t'(cfg.loop_length);
    tot_minus_ls   = total_r - ls_r;
    len_calc       = (ll_s > tot_minus_ls) ? tot_minus_ls : ll_s;
    loop_usable    = cfg.loop_enabled && (len_calc != '0);
    start_ge_total = start_s >= total_r;
    silent_case    = item_r.span_begin[31] || (start_ge_total && !loop_usable);
    dividend       = DVD_W'(start_s - total_r);
    diff           = e_r - s_r;
    cnt_calc       = (wrap_r && (width_r < diff)) ? width_r : diff;
    if (cnt_calc < span_t'(1)) begin
      cnt_calc = span_t'(1);
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      F_IDLE: begin
        if (in_ch.valid) begin
          if (in_ch.data.req_type == REQ_QUERY) state_nxt = F_PREP;
          else if (load_ok)                     state_nxt = F_PUSH;
        end
      end
      F_PREP:  state_nxt = F_LOOP;
      F_LOOP:  state_nxt = (total_r == '0 || nch_r == '0) ? F_IDLE : F_CLASS;
      F_CLASS: begin
        if (silent_case)         state_nxt = F_PUSH;
        else if (start_ge_total) state_nxt = F_DIV;
        else                     state_nxt = F_FIN1;
      end
      F_DIV:   if (div_done) state_nxt = F_FIN1;
      F_FIN1:  state_nxt = F_FIN2;
      F_FIN2:  state_nxt = F_PUSH;
      F_PUSH:  if (!q_full) state_nxt = F_IDLE;
      default: state_nxt = F_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    in_ch.ready = 1'b0;
    push        = 1'b0;
    div_start   = 1'b0;
    case (state_r)
      F_IDLE:  in_ch.ready = 1'b1;
      F_CLASS: div_start = !silent_case && start_ge_total;
      F_PUSH:  push = !q_full;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= F_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    case (state_r)
      F_IDLE: begin
        item_r             <= in_ch.data;
        cmd_r.is_load      <= (in_ch.data.req_type == REQ_LOAD);
        cmd_r.load_channel <= in_ch.data.load_channel;
        cmd_r.load_frame   <= in_ch.data.load_frame;
        cmd_r.load_sample  <= in_ch.data.load_sample;
      end
      F_PREP: begin
        total_r <= (span_t'(cfg.frame_total) > MAX_FRAMES_S) ? MAX_FRAMES_S
                                                            : span_t'(cfg.frame_total);
        nch_r   <= (32'(cfg.channel_count) > 32'(MAX_CHANNELS)) ? 4'(MAX_CHANNELS)
                                                               : cfg.channel_count;
        width_r <= end_s - start_s;
      end
      F_LOOP: begin
        ls_r <= (span_t'(cfg.loop_start) > total_r - span_t'(1)) ? total_r - span_t'(1)
                                                                 : span_t'(cfg.loop_start);
        if (width_r < span_t'(1)) width_r <= span_t'(1);
        cmd_r.nch <= nch_r;
      end
      F_CLASS: begin
        len_r        <= DSR_W'(len_calc);
        wrap_r       <= start_ge_total;
        cmd_r.silent <= silent_case;
        s_r          <= start_s;
      end
      F_FIN1: begin
        if (wrap_r) begin
          s_r <= ls_r + span_t'(div_rem);
          e_r <= ls_r + span_t'(len_r);
        end else begin
          e_r <= (end_s > total_r) ? total_r : end_s;
        end
      end
      F_FIN2: begin
        cmd_r.first <= FRAME_MAX_W'(s_r);
        cmd_r.count <= COUNT_W'(cnt_calc);
      end
      default: ;
    endcase
  end

  wpd_divmod u_divmod (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (div_start),
    .dividend  (dividend),
    .divisor   (DSR_W'(len_calc)),
    .done      (div_done),
    .remainder (div_rem)
  );

  assign cmd = cmd_r;

endmodule

// ----- design/wpd_back.sv -----
module wpd_back import wpd_pkg::*; #(
  parameter int MAX_FRAMES   = 65536,
  parameter int MAX_CHANNELS = 2
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         q_empty,
  input  cmd_t         q_head,
  output logic         pop,
  wpd_stream_if.source out_ch
);

  localparam int FRAME_W = $clog2(MAX_FRAMES);
  localparam int CH_W    = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
  localparam int AW      = CH_W + FRAME_W;
  localparam int DEPTH   = 1 << AW;

  back_state_t        state_r, state_nxt;
  cmd_t               cmd_r;
  logic [2:0]         ch_r;
  logic [FRAME_W-1:0] frame_r;
  logic [COUNT_W-1:0] left_r;
  logic               rvalid_r;
  logic [15:0]        min_r;
  logic [15:0]        max_r;
  logic               out_valid_r;
  out_item_t          out_r;

  logic               ram_we;
  logic               ram_re;
  logic               emit;
  logic               ch_last;
  logic [15:0]        rdata;
  logic [15:0]        lvl;
  logic [AW-1:0]      waddr;
  logic [AW-1:0]      raddr;

  assign ch_last = ({1'b0, ch_r} + 4'd1) == cmd_r.nch;
  assign lvl     = rdata ^ SIGN_FLIP;
  assign waddr   = {CH_W'(q_head.load_channel), FRAME_W'(q_head.load_frame)};
  assign raddr   = {CH_W'(ch_r), frame_r};

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      B_IDLE: begin
        if (!q_empty && !q_head.is_load) begin
          state_nxt = q_head.silent ? B_EMIT : B_SCAN;
        end
      end
      B_SCAN:  if (left_r == COUNT_W'(1)) state_nxt = B_DRAIN;
      B_DRAIN: state_nxt = B_EMIT;
      B_EMIT: begin
        if (!out_valid_r || out_ch.ready) begin
          if (ch_last)           state_nxt = B_IDLE;
          else if (cmd_r.silent) state_nxt = B_EMIT;
          else                   state_nxt = B_SCAN;
        end
      end
      default: state_nxt = B_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    pop    = 1'b0;
    ram_we = 1'b0;
    ram_re = 1'b0;
    emit   = 1'b0;
    case (state_r)
      B_IDLE: begin
        pop    = !q_empty;
        ram_we = !q_empty && q_head.is_load;
      end
      B_SCAN:  ram_re = 1'b1;
      B_EMIT:  emit = !out_valid_r || out_ch.ready;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= B_IDLE;
      rvalid_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      rvalid_r <= ram_re;
      if (emit)              out_valid_r <= 1'b1;
      else if (out_ch.ready) out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop && !q_head.is_load) begin
      cmd_r   <= q_head;
      ch_r    <= '0;
      frame_r <= q_head.first[FRAME_W-1:0];
      left_r  <= q_head.count;
      min_r   <= LEVEL_TOP;
      max_r   <= '0;
    end else if (emit) begin
      ch_r    <= ch_r + 3'd1;
      frame_r <= cmd_r.first[FRAME_W-1:0];
      left_r  <= cmd_r.count;
      min_r   <= LEVEL_TOP;
      max_r   <= '0;
    end else begin
      if (ram_re) begin
        frame_r <= frame_r + FRAME_W'(1);
        left_r  <= left_r - COUNT_W'(1);
      end
      if (rvalid_r) begin
        if (lvl < min_r) min_r <= lvl;
        if (lvl > max_r) max_r <= lvl;
      end
    end
    if (emit) begin
      out_r.channel   <= ch_r;
      out_r.min_level <= cmd_r.silent ? SILENCE_LEVEL : min_r;
      out_r.max_level <= cmd_r.silent ? SILENCE_LEVEL : max_r;
      out_r.last      <= ch_last;
    end
  end

  wpd_ram #(
    .WIDTH (16),
    .DEPTH (DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (waddr),
    .wdata (q_head.load_sample),
    .re    (ram_re),
    .raddr (raddr),
    .rdata (rdata)
  );

  assign out_ch.valid = out_valid_r;
  assign out_ch.data  = out_r;

endmodule

// ----- test/tb_top.sv -----
`timescale 1ns / 100ps

module tb_top;
  import wpd_pkg::*;

  localparam int STORE_FRAMES = 65536;
  localparam int STORE_CHANS  = 2;
  localparam int STALL_LIMIT  = 20000;   // cycles with no transaction on either side
  localparam int SETTLE       = 64;      // idle cycles before a register write

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  logic [2:0] cfg_index = '0;
  logic [CFG_W-1:0] cfg_data = '0;

  wpd_stream_if #(.T(in_item_t)) in_ch ();
  wpd_stream_if #(.T(out_item_t)) out_ch ();

  waveform_peak_decimator_core #(
    .MAX_FRAMES  (STORE_FRAMES),
    .MAX_CHANNELS(STORE_CHANS)
  ) u_top (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_ch    (in_ch),
    .out_ch   (out_ch),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // shadow of the block: sample store, which entries hold data, registers
  logic [15:0] shadow_store [STORE_CHANS][STORE_FRAMES];
  bit          loaded       [STORE_CHANS][STORE_FRAMES];
  logic [16:0] sh_total = 17'd65536;
  logic [15:0] sh_lstart = '0;
  logic [16:0] sh_llen = '0;
  logic        sh_lena = 1'b0;
  logic [3:0]  sh_chans = 4'd2;

  out_item_t   peak_q[$];          // peaks still owed by the block
  int          errors = 0;
  int          n_loads = 0;
  int          n_queries = 0;
  int          n_peaks = 0;
  int          n_silent = 0;
  int          n_wraps = 0;

  // sender / receiver idling controls
  bit          steady = 1'b1;      // no gaps on either side while set
  int          hold_off = 0;       // requested long receiver stall

  initial begin
    in_ch.valid = 1'b0;
    in_ch.data = '0;
    out_ch.ready = 1'b0;
  end

  function automatic int pick_gap();
    if ($urandom_range(0, 9) == 0) return $urandom_range(10, 40);
    return $urandom_range(1, 3);
  endfunction

  // resolve a query span the way the block does; returns channels answered
  function automatic int resolve_span(in_item_t it, output bit silent, output bit wrapped,
                                      output longint first, output longint cnt);
    longint tot, ls, len, s, e, w;
    int nch;
    tot = (sh_total > STORE_FRAMES) ? STORE_FRAMES : sh_total;
    nch = (sh_chans > STORE_CHANS) ? STORE_CHANS : sh_chans;
    silent = 1'b0;
    wrapped = 1'b0;
    first = 0;
    cnt = 0;
    if (tot == 0 || nch == 0) return 0;
    ls = sh_lstart;
    if (ls > tot - 1) ls = tot - 1;
    len = sh_llen;
    if (len > tot - ls) len = tot - ls;
    s = longint'($signed(it.span_begin));
    e = longint'($signed(it.span_end));
    if (s < 0) begin
      silent = 1'b1;
    end else if (s >= tot && sh_lena && len > 0) begin
      // past the buffer: fold into the loop region, keep the width
      wrapped = 1'b1;
      w = e - s;
      if (w < 1) w = 1;
      s = ls + (s - tot) % len;
      e = s + w;
      if (e > ls + len) e = ls + len;
    end else if (s >= tot) begin
      silent = 1'b1;
    end else if (e > tot) begin
      e = tot;
    end
    first = s;
    cnt = e - s;
    if (cnt < 1) cnt = 1;
    return nch;
  endfunction

  // a query may only touch store entries that were loaded
  function automatic bit span_loaded(in_item_t it);
    bit silent, wrapped;
    longint first, cnt;
    int nch;
    nch = resolve_span(it, silent, wrapped, first, cnt);
    if (nch == 0 || silent) return 1'b1;
    for (int ch = 0; ch < nch; ch++)
      for (longint f = first; f < first + cnt; f++)
        if (!loaded[ch][f]) return 1'b0;
    return 1'b1;
  endfunction

  // update the shadow for an accepted transaction and queue its peaks
  function automatic void forecast_peaks(in_item_t it);
    bit silent, wrapped;
    longint first, cnt;
    int nch;
    logic [15:0] lvl;
    out_item_t pk;
    if (it.req_type == REQ_LOAD) begin
      n_loads++;
      if (it.load_channel < STORE_CHANS) begin
        shadow_store[it.load_channel][it.load_frame] = it.load_sample;
        loaded[it.load_channel][it.load_frame] = 1'b1;
      end
      return;
    end
    n_queries++;
    nch = resolve_span(it, silent, wrapped, first, cnt);
    if (silent) n_silent++;
    if (wrapped) n_wraps++;
    for (int ch = 0; ch < nch; ch++) begin
      pk.channel = ch[2:0];
      pk.last = (ch + 1 == nch);
      if (silent) begin
        pk.min_level = SILENCE_LEVEL;
        pk.max_level = SILENCE_LEVEL;
      end else begin
        pk.min_level = LEVEL_TOP;
        pk.max_level = '0;
        for (longint f = first; f < first + cnt; f++) begin
          lvl = shadow_store[ch][f] ^ SIGN_FLIP;
          if (lvl < pk.min_level) pk.min_level = lvl;
          if (lvl > pk.max_level) pk.max_level = lvl;
        end
      end
      peak_q.push_back(pk);
    end
  endfunction

  // offer one transaction, hold it until accepted, then maybe idle
  task automatic send_item(in_item_t it);
    int gap;
    in_ch.valid <= 1'b1;
    in_ch.data <= it;
    do @(posedge clk); while (!in_ch.ready);
    forecast_peaks(it);
    gap = steady ? 0 : (($urandom_range(0, 2) == 0) ? pick_gap() : 0);
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic send_load(int ch, int frame, int sample);
    in_item_t it;
    it.req_type = REQ_LOAD;
    it.load_channel = ch[2:0];
    it.load_frame = frame[15:0];
    it.load_sample = sample[15:0];
    it.span_begin = $urandom;
    it.span_end = $urandom;
    send_item(it);
  endtask

  task automatic send_query(int s, int e);
    in_item_t it;
    it.req_type = REQ_QUERY;
    it.load_channel = $urandom;
    it.load_frame = $urandom;
    it.load_sample = $urandom;
    it.span_begin = s;
    it.span_end = e;
    send_item(it);
  endtask

  // registers change only with the block drained and quiet
  task automatic write_reg(cfg_idx_t idx, int value);
    in_ch.valid <= 1'b0;
    wait (peak_q.size() == 0);
    repeat (SETTLE) @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value[CFG_W-1:0];
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      CFG_FRAME_TOTAL:   sh_total = value[16:0];
      CFG_LOOP_START:    sh_lstart = value[15:0];
      CFG_LOOP_LENGTH:   sh_llen = value[16:0];
      CFG_LOOP_ENABLED:  sh_lena = value[0];
      CFG_CHANNEL_COUNT: sh_chans = value[3:0];
      default: ;
    endcase
  endtask

  task automatic setup_regs(int tot, int ls, int len, int ena, int chans);
    write_reg(CFG_FRAME_TOTAL, tot);
    write_reg(CFG_LOOP_START, ls);
    write_reg(CFG_LOOP_LENGTH, len);
    write_reg(CFG_LOOP_ENABLED, ena);
    write_reg(CFG_CHANNEL_COUNT, chans);
  endtask

  // random load: mostly near the start of the buffer, every channel index
  task automatic random_load();
    int frame;
    frame = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 65535) : $urandom_range(0, 72);
    send_load($urandom_range(0, 7), frame, $urandom);
  endtask

  // random query that only touches loaded entries
  task automatic random_query();
    in_item_t it;
    int tot;
    bit ok;
    tot = sh_total;
    it.req_type = REQ_QUERY;
    ok = 1'b0;
    for (int tries = 0; tries < 30 && !ok; tries++) begin
      it.load_channel = $urandom;
      it.load_frame = $urandom;
      it.load_sample = $urandom;
      case ($urandom_range(0, 4))
        0, 1: begin
          it.span_begin = $urandom_range(0, 70) - 3;
          it.span_end = it.span_begin + $urandom_range(0, 24) - 4;
        end
        2: begin
          it.span_begin = tot + $urandom_range(0, 300);
          it.span_end = it.span_begin + $urandom_range(0, 20) - 2;
        end
        3: begin
          it.span_begin = $urandom;
          it.span_end = $urandom;
        end
        default: begin
          it.span_begin = $urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h8000_0000;
          it.span_end = $urandom_range(0, 1) ? 32'h7FFF_FFFF : $urandom;
        end
      endcase
      ok = span_loaded(it);
    end
    if (!ok) begin
      it.span_begin = -1;
      it.span_end = 4;
    end
    send_item(it);
  endtask

  // ---------------------------------------------------------------- tests

  // fill the start of both channel rows and the very last frame
  task automatic test_preload();
    for (int f = 0; f < 64; f++) begin
      send_load(0, f, $urandom);
      send_load(1, f, $urandom);
    end
    send_load(0, 65535, 16'h7FFF);
    send_load(1, 65535, 16'h8000);
  endtask

  // reset registers: edges of the span rules, sample extremes
  task automatic test_span_edges();
    send_load(0, 3, 16'h8000);         // most negative sample
    send_load(1, 3, 16'h7FFF);         // most positive sample
    send_load(7, 65535, 16'h1234);     // channel beyond the store, dropped
    send_load(2, 0, 16'hFFFF);         // dropped as well
    send_query(0, 1);
    send_query(0, 64);
    send_query(5, 5);                  // empty span covers one frame
    send_query(10, 3);                 // reversed span
    send_query(-1, 5);                 // negative start is silence
    send_query(32'h8000_0000, 32'h7FFF_FFFF);
    send_query(65536, 65600);          // past the end with no loop
    send_query(32'h7FFF_FFFF, 0);
    send_query(65535, 32'h7FFF_FFFF);  // end clamped to the buffer
  endtask

  // loop region wrap, clamped loop length, channel count extremes
  task automatic test_loop_wrap();
    setup_regs(64, 8, 16, 1, 2);
    send_query(64, 70);
    send_query(100, 99);
    send_query(32'h7FFF_FFFF, 32'h8000_0000);
    send_query(63, 1000);
    send_query(79, 200);               // wide span limited to the loop end
    setup_regs(65536, 65535, 65536, 1, 8);
    send_query(65536, 65540);          // loop collapses to the last frame
    send_query(32'h7FFF_FFFF, 32'h7FFF_FFFF);
    setup_regs(1, 0, 0, 1, 1);
    send_query(0, 1);
    send_query(1, 2);                  // loop enabled but empty: silence
    send_query(0, 32'h7FFF_FFFF);
  endtask

  // random traffic over several register settings
  task automatic test_random_traffic();
    int tot;
    steady = 1'b0;
    for (int phase = 0; phase < 5; phase++) begin
      case (phase)
        0: tot = 64;
        1: tot = 48;
        2: tot = 65536;
        3: tot = 1;
        default: tot = $urandom_range(2, 72);
      endcase
      setup_regs(tot, ($urandom_range(0, 3) == 0) ? 65535 : $urandom_range(0, 60),
                 ($urandom_range(0, 3) == 0) ? 65536 : $urandom_range(0, 24),
                 (phase == 1) ? 0 : 1, (phase == 3) ? 1 : (phase == 2 ? 8 : 2));
      // stretch of back-to-back traffic first, then gaps
      steady = 1'b1;
      for (int k = 0; k < 18; k++) begin
        if (k == 8) steady = 1'b0;
        if ($urandom_range(0, 9) < 4) random_load();
        else random_query();
      end
    end
  endtask

  // receiver stalls for a long stretch while queries keep coming
  task automatic test_backpressure();
    setup_regs(64, 0, 64, 1, 2);
    steady = 1'b1;
    hold_off = 400;
    for (int k = 0; k < 20; k++) random_query();
    steady = 1'b0;
  endtask

  // ---------------------------------------------------------------- checking

  task automatic report_mismatch(string what, int got, int want);
    errors++;
    $display("mismatch %s at %0t: got %0d expected %0d", what, $realtime, got, want);
  endtask

  always @(posedge clk) begin
    out_item_t exp_pk;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      n_peaks++;
      if (peak_q.size() == 0) begin
        report_mismatch("unexpected peak, channel", out_ch.data.channel, -1);
      end else begin
        exp_pk = peak_q.pop_front();
        if (out_ch.data.channel !== exp_pk.channel)
          report_mismatch("channel", out_ch.data.channel, exp_pk.channel);
        if (out_ch.data.min_level !== exp_pk.min_level)
          report_mismatch("min_level", out_ch.data.min_level, exp_pk.min_level);
        if (out_ch.data.max_level !== exp_pk.max_level)
          report_mismatch("max_level", out_ch.data.max_level, exp_pk.max_level);
        if (out_ch.data.last !== exp_pk.last)
          report_mismatch("last", out_ch.data.last, exp_pk.last);
      end
    end
  end

  // result side readiness: random gaps, a long hold-off on request
  initial begin
    int gap_left;
    gap_left = 0;
    forever begin
      @(posedge clk);
      if (hold_off > 0) begin
        out_ch.ready <= 1'b0;
        hold_off--;
      end else if (gap_left > 0 && !steady) begin
        out_ch.ready <= 1'b0;
        gap_left--;
      end else begin
        out_ch.ready <= 1'b1;
        gap_left = ($urandom_range(0, 5) == 0) ? pick_gap() : 0;
      end
    end
  end

  // watchdog: too long with no transaction on either channel
  initial begin
    int quiet;
    quiet = 0;
    forever begin
      @(posedge clk);
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) quiet = 0;
      else quiet++;
      if (quiet >= STALL_LIMIT) begin
        $display("timeout: no transaction for %0d cycles", STALL_LIMIT);
        $display("[FAIL] regression broken");
        $finish;
      end
    end
  end

  // ---------------------------------------------------------------- sequence

  initial begin
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_preload();
    test_span_edges();
    test_loop_wrap();
    test_random_traffic();
    test_backpressure();
    in_ch.valid <= 1'b0;
    wait (peak_q.size() == 0);
    repeat (SETTLE) @(posedge clk);
    $display("covered %0d loads and %0d queries (%0d silent, %0d wrapped into the loop)",
             n_loads, n_queries, n_silent, n_wraps);
    $display("checked %0d peak transactions, %0d mismatches", n_peaks, errors);
    if (errors == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
